// ===== sv/nv_record_commit_controller_macros.svh =====
`ifndef NV_RECORD_COMMIT_CONTROLLER_MACROS_SVH
`define NV_RECORD_COMMIT_CONTROLLER_MACROS_SVH

// Both macros sample on the rising edge of clock and are disabled during reset.
`define NVRC_ASSERT_IMPLY(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

`define NVRC_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== sv/nvrc_pkg.sv =====
package nvrc_pkg;

   localparam int unsigned RECORD_LEN_DEFAULT = 32;
   localparam int unsigned MARK_ADDR_DEFAULT  = 34;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [7:0]  MAGIC_0  = 8'h4B;
   localparam logic [7:0]  MAGIC_1  = 8'h43;

   localparam logic [7:0] SCHEMA_RESET = 8'h00;
   localparam logic [7:0] MARK_RESET   = 8'hA5;

   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCHEMA_ID   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMIT_MARK = 1'b1;

   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int unsigned RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [2:0] {
      CMD_SET  = 3'd0,
      CMD_GET  = 3'd1,
      CMD_LOAD = 3'd2,
      CMD_SAVE = 3'd3,
      CMD_DATA = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_KEY   = 2'd2,
      KIND_DONE  = 2'd3
   } kind_type;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'd0,
      PH_LHDR   = 5'd1,
      PH_LBODY  = 5'd2,
      PH_LCRCLO = 5'd3,
      PH_LCRCHI = 5'd4,
      PH_SSCAN  = 5'd5,
      PH_SCRCLO = 5'd6,
      PH_SCRCHI = 5'd7,
      PH_SMARK  = 5'd8,
      PH_WMARK0 = 5'd9,
      PH_VMARK0 = 5'd10,
      PH_WDATA  = 5'd11,
      PH_VDATA  = 5'd12,
      PH_WMARK1 = 5'd13,
      PH_VMARK1 = 5'd14
   } phase_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [4:0] key_slot;
      logic [7:0] key_byte;
      logic [7:0] read_byte;
   } item_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] mem_address;
      logic [7:0] mem_wdata;
      logic [7:0] key_data;
      logic       status;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int b = 0; b < 8; b++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   function automatic rsp_type make_rsp(input kind_type kind, input logic [7:0] addr,
                                        input logic [7:0] wdata, input logic [7:0] key,
                                        input logic status);
      rsp_type r;
      r.kind        = kind;
      r.mem_address = addr;
      r.mem_wdata   = wdata;
      r.key_data    = key;
      r.status      = status;
      r.last        = 1'b0;
      return r;
   endfunction

endpackage

// ===== sv/nv_record_commit_controller.sv =====
// Settings record controller for a byte-wide nonvolatile memory.
// The req channel carries commands: set key byte, get key byte, start load,
// start save, and memory read data returned for the last read request.
// The rsp channel carries memory read and write requests, key bytes and a
// done beat with status; last marks the final beat caused by one req beat.
// The csr port writes the schema byte and the commit mark value at any edge
// with csr_wr_en high; write it only while the block is idle (unchecked).
// An accepted req beat is held in the input register; the engine works on
// it combinationally and its results go into a four-entry response queue,
// which registers them. A req beat can be accepted every cycle while the
// queue has room; a beat that raises a write request gives two rsp beats,
// so the rsp port limits the sustained rate to one rsp beat per cycle.
// The req side stalls only while the queue cannot take two more beats.
// When the receiver stalls, rsp beats wait in the queue unchanged.
// Reset clears the key store, the engine state and the queue, and loads
// the csr defaults: schema 0 and commit mark 0xA5.
module nv_record_commit_controller #(
   parameter int unsigned RECORD_LEN = nvrc_pkg::RECORD_LEN_DEFAULT,
   parameter int unsigned MARK_ADDR  = nvrc_pkg::MARK_ADDR_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [nvrc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [2:0]                     req_cmd,
   input  logic [4:0]                     req_key_slot,
   input  logic [7:0]                     req_key_byte,
   input  logic [7:0]                     req_read_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_kind,
   output logic [7:0]                     rsp_mem_address,
   output logic [7:0]                     rsp_mem_wdata,
   output logic [7:0]                     rsp_key_data,
   output logic                           rsp_status,
   output logic                           rsp_last
);
   import nvrc_pkg::*;

   item_type item;
   logic     item_valid;
   logic     take;
   logic     room;
   push_type push;
   rsp_type  head;

   nvrc_req_reg u_req_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_key_slot  (req_key_slot),
      .req_key_byte  (req_key_byte),
      .req_read_byte (req_read_byte),
      .take          (take),
      .item_valid    (item_valid),
      .item          (item)
   );

   nvrc_engine #(
      .RECORD_LEN (RECORD_LEN),
      .MARK_ADDR  (MARK_ADDR)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item       (item),
      .room       (room),
      .take       (take),
      .push       (push)
   );

   nvrc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_kind        = head.kind;
   assign rsp_mem_address = head.mem_address;
   assign rsp_mem_wdata   = head.mem_wdata;
   assign rsp_key_data    = head.key_data;
   assign rsp_status      = head.status;
   assign rsp_last        = head.last;

endmodule

// ===== sv/nvrc_req_reg.sv =====
module nvrc_req_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_cmd,
   input  logic [4:0]        req_key_slot,
   input  logic [7:0]        req_key_byte,
   input  logic [7:0]        req_read_byte,
   input  logic              take,
   output logic              item_valid,
   output nvrc_pkg::item_type item
);
   import nvrc_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in          = 1'b1;
         item_in.cmd       = req_cmd;
         item_in.key_slot  = req_key_slot;
         item_in.key_byte  = req_key_byte;
         item_in.read_byte = req_read_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== sv/nvrc_engine.sv =====
`include "nv_record_commit_controller_macros.svh"

module nvrc_engine #(
   parameter int unsigned RECORD_LEN = nvrc_pkg::RECORD_LEN_DEFAULT,
   parameter int unsigned MARK_ADDR  = nvrc_pkg::MARK_ADDR_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [nvrc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [7:0]                        csr_wdata,
   input  logic                              item_valid,
   input  nvrc_pkg::item_type                item,
   input  logic                              room,
   output logic                              take,
   output nvrc_pkg::push_type                push
);
   import nvrc_pkg::*;

   localparam int unsigned NUM_KEYS  = RECORD_LEN - 3;
   localparam int unsigned KIDX_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam logic [7:0]  KEY_CNT8  = 8'(NUM_KEYS);
   localparam logic [7:0]  RL8       = 8'(RECORD_LEN);
   localparam logic [7:0]  RL1       = 8'(RECORD_LEN + 1);
   localparam logic [7:0]  RL2       = 8'(RECORD_LEN + 2);
   localparam logic [7:0]  MARK8     = 8'(MARK_ADDR);

   phase_type   phase_ff, phase_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  bp_ff, bp_in;
   logic        unch_ff, unch_in;
   logic [7:0]  schema_ff;
   logic [7:0]  mark_ff;
   logic [7:0]  key_store_ff [NUM_KEYS];

   logic        idle;
   logic        is_data;
   logic [7:0]  d;
   logic [7:0]  bp_inc;
   logic [7:0]  store_addr;
   logic        key_hit;
   logic [7:0]  key_rd;
   logic [7:0]  rec_byte;
   logic [7:0]  hdr_want;
   logic [15:0] crc_next;
   logic [7:0]  wa;
   logic [7:0]  wv;
   logic        key_we;
   logic [7:0]  key_wdata;
   rsp_type     r0, r1;
   logic [1:0]  cnt;
   logic        done_beat;
   logic        busy_cmd;

   assign idle       = (phase_ff == PH_IDLE);
   assign take       = item_valid && room;
   assign is_data    = (item.cmd == CMD_DATA);
   assign d          = item.read_byte;
   assign bp_inc     = bp_ff + 8'd1;
   assign store_addr = idle ? {3'b000, item.key_slot} : (bp_ff - 8'd3);
   assign key_hit    = (store_addr < KEY_CNT8);
   assign key_rd     = key_hit ? key_store_ff[store_addr[KIDX_W-1:0]] : 8'h00;

   always_comb begin
      case (bp_ff)
         8'd0:    rec_byte = MAGIC_0;
         8'd1:    rec_byte = MAGIC_1;
         8'd2:    rec_byte = schema_ff;
         default: rec_byte = key_rd;
      endcase
   end

   always_comb begin
      case (bp_ff)
         8'd0:    hdr_want = mark_ff;
         8'd1:    hdr_want = MAGIC_0;
         8'd2:    hdr_want = MAGIC_1;
         default: hdr_want = schema_ff;
      endcase
   end

   assign crc_next = crc_step(crc_ff, (phase_ff == PH_LBODY) ? d : rec_byte);

   always_comb begin
      case (phase_ff)
         PH_WDATA, PH_VDATA: begin
            wa = bp_ff;
            if (bp_ff < RL8) begin
               wv = rec_byte;
            end else if (bp_ff == RL8) begin
               wv = crc_ff[7:0];
            end else begin
               wv = crc_ff[15:8];
            end
         end
         PH_WMARK1, PH_VMARK1: begin
            wa = MARK8;
            wv = mark_ff;
         end
         default: begin
            wa = MARK8;
            wv = 8'h00;
         end
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      crc_in    = crc_ff;
      bp_in     = bp_ff;
      unch_in   = unch_ff;
      key_we    = 1'b0;
      key_wdata = item.key_byte;
      r0        = make_rsp(KIND_READ, 8'h00, 8'h00, 8'h00, 1'b0);
      r1        = make_rsp(KIND_READ, 8'h00, 8'h00, 8'h00, 1'b0);
      cnt       = 2'd0;
      if (idle) begin
         case (item.cmd)
            CMD_SET: begin
               key_we = key_hit;
            end
            CMD_GET: begin
               r0  = make_rsp(KIND_KEY, 8'h00, 8'h00, key_rd, 1'b0);
               cnt = 2'd1;
            end
            CMD_LOAD: begin
               crc_in   = CRC_INIT;
               bp_in    = 8'd0;
               phase_in = PH_LHDR;
               r0       = make_rsp(KIND_READ, MARK8, 8'h00, 8'h00, 1'b0);
               cnt      = 2'd1;
            end
            CMD_SAVE: begin
               crc_in   = CRC_INIT;
               bp_in    = 8'd0;
               unch_in  = 1'b1;
               phase_in = PH_SSCAN;
               r0       = make_rsp(KIND_READ, 8'h00, 8'h00, 8'h00, 1'b0);
               cnt      = 2'd1;
            end
            default: begin
            end
         endcase
      end else if (is_data) begin
         cnt = 2'd1;
         case (phase_ff)
            PH_LHDR: begin
               if (d != hdr_want) begin
                  r0       = make_rsp(KIND_DONE, 8'h00, 8'h00, 8'h00, 1'b1);
                  phase_in = PH_IDLE;
               end else if (bp_ff < 8'd3) begin
                  bp_in = bp_inc;
                  r0    = make_rsp(KIND_READ, bp_ff, 8'h00, 8'h00, 1'b0);
               end else begin
                  phase_in = PH_LBODY;
                  bp_in    = 8'd0;
                  r0       = make_rsp(KIND_READ, 8'h00, 8'h00, 8'h00, 1'b0);
               end
            end
            PH_LBODY: begin
               crc_in    = crc_next;
               key_we    = key_hit;
               key_wdata = d;
               bp_in     = bp_inc;
               if (bp_inc < RL8) begin
                  r0 = make_rsp(KIND_READ, bp_inc, 8'h00, 8'h00, 1'b0);
               end else begin
                  phase_in = PH_LCRCLO;
                  r0       = make_rsp(KIND_READ, RL8, 8'h00, 8'h00, 1'b0);
               end
            end
            PH_LCRCLO: begin
               if (d != crc_ff[7:0]) begin
                  r0       = make_rsp(KIND_DONE, 8'h00, 8'h00, 8'h00, 1'b1);
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_LCRCHI;
                  r0       = make_rsp(KIND_READ, RL1, 8'h00, 8'h00, 1'b0);
               end
            end
            PH_LCRCHI: begin
               r0       = make_rsp(KIND_DONE, 8'h00, 8'h00, 8'h00, d != crc_ff[15:8]);
               phase_in = PH_IDLE;
            end
            PH_SSCAN: begin
               crc_in = crc_next;
               bp_in  = bp_inc;
               if (d != rec_byte) begin
                  unch_in = 1'b0;
               end
               if (bp_inc < RL8) begin
                  r0 = make_rsp(KIND_READ, bp_inc, 8'h00, 8'h00, 1'b0);
               end else if (!unch_ff || (d != rec_byte)) begin
                  phase_in = PH_WMARK0;
                  bp_in    = 8'd0;
                  r0       = make_rsp(KIND_READ, MARK8, 8'h00, 8'h00, 1'b0);
               end else begin
                  phase_in = PH_SCRCLO;
                  r0       = make_rsp(KIND_READ, RL8, 8'h00, 8'h00, 1'b0);
               end
            end
            PH_SCRCLO, PH_SCRCHI, PH_SMARK: begin
               if (((phase_ff == PH_SCRCLO) && (d != crc_ff[7:0])) ||
                   ((phase_ff == PH_SCRCHI) && (d != crc_ff[15:8])) ||
                   ((phase_ff == PH_SMARK) && (d != mark_ff))) begin
                  unch_in  = 1'b0;
                  phase_in = PH_WMARK0;
                  bp_in    = 8'd0;
                  r0       = make_rsp(KIND_READ, MARK8, 8'h00, 8'h00, 1'b0);
               end else if (phase_ff == PH_SCRCLO) begin
                  phase_in = PH_SCRCHI;
                  r0       = make_rsp(KIND_READ, RL1, 8'h00, 8'h00, 1'b0);
               end else if (phase_ff == PH_SCRCHI) begin
                  phase_in = PH_SMARK;
                  r0       = make_rsp(KIND_READ, MARK8, 8'h00, 8'h00, 1'b0);
               end else begin
                  r0       = make_rsp(KIND_DONE, 8'h00, 8'h00, 8'h00, 1'b0);
                  phase_in = PH_IDLE;
               end
            end
            PH_WMARK0, PH_WDATA, PH_WMARK1: begin
               phase_in = phase_type'(phase_ff + 5'd1);
               if (d != wv) begin
                  r0  = make_rsp(KIND_WRITE, wa, wv, 8'h00, 1'b0);
                  r1  = make_rsp(KIND_READ, wa, 8'h00, 8'h00, 1'b0);
                  cnt = 2'd2;
               end else begin
                  r0 = make_rsp(KIND_READ, wa, 8'h00, 8'h00, 1'b0);
               end
            end
            PH_VMARK0, PH_VDATA, PH_VMARK1: begin
               if (d != wv) begin
                  r0       = make_rsp(KIND_DONE, 8'h00, 8'h00, 8'h00, 1'b1);
                  phase_in = PH_IDLE;
               end else if (phase_ff == PH_VMARK0) begin
                  phase_in = PH_WDATA;
                  bp_in    = 8'd0;
                  r0       = make_rsp(KIND_READ, 8'h00, 8'h00, 8'h00, 1'b0);
               end else if ((phase_ff == PH_VDATA) && (bp_inc < RL2)) begin
                  phase_in = PH_WDATA;
                  bp_in    = bp_inc;
                  r0       = make_rsp(KIND_READ, bp_inc, 8'h00, 8'h00, 1'b0);
               end else if (phase_ff == PH_VDATA) begin
                  phase_in = PH_WMARK1;
                  r0       = make_rsp(KIND_READ, MARK8, 8'h00, 8'h00, 1'b0);
               end else begin
                  r0       = make_rsp(KIND_DONE, 8'h00, 8'h00, 8'h00, 1'b0);
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               cnt = 2'd0;
            end
         endcase
      end
      if (cnt == 2'd1) begin
         r0.last = 1'b1;
      end
      if (cnt == 2'd2) begin
         r1.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         crc_ff   <= CRC_INIT;
         bp_ff    <= 8'd0;
         unch_ff  <= 1'b1;
      end else if (take) begin
         phase_ff <= phase_in;
         crc_ff   <= crc_in;
         bp_ff    <= bp_in;
         unch_ff  <= unch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         schema_ff <= SCHEMA_RESET;
         mark_ff   <= MARK_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SCHEMA_ID:   schema_ff <= csr_wdata;
            CSR_COMMIT_MARK: mark_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            key_store_ff[i] <= 8'h00;
         end
      end else if (take && key_we) begin
         key_store_ff[store_addr[KIDX_W-1:0]] <= key_wdata;
      end
   end

   always_comb begin
      push.count  = take ? cnt : 2'd0;
      push.first  = r0;
      push.second = r1;
   end

   assign done_beat = take && (cnt == 2'd1) && (r0.kind == KIND_DONE);
   assign busy_cmd  = take && !idle && !is_data;

   `NVRC_ASSERT_NEXT(a_done_returns_idle, done_beat, phase_ff == PH_IDLE, "done left engine busy")
   `NVRC_ASSERT_IMPLY(a_busy_ignores_cmds, busy_cmd, push.count == 2'd0, "busy cmd gave a beat")

endmodule

// ===== sv/nvrc_rsp_queue.sv =====
`include "nv_record_commit_controller_macros.svh"

module nvrc_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  nvrc_pkg::push_type push,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output nvrc_pkg::rsp_type  head
);
   import nvrc_pkg::*;

   rsp_type                q_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ff, wr_in;
   logic [RSP_PTR_W-1:0]   rd_ff, rd_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic [RSP_PTR_W-1:0]   wr_next;
   logic                   pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign head      = q_ff[rd_ff];
   assign wr_next   = wr_ff + RSP_PTR_W'(1);

   always_comb begin
      wr_in    = wr_ff + RSP_PTR_W'(push.count);
      rd_in    = pop ? (rd_ff + RSP_PTR_W'(1)) : rd_ff;
      count_in = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         q_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         q_ff[wr_next] <= push.second;
      end
   end

   `NVRC_ASSERT_IMPLY(a_push_has_room, push.count != 2'd0, count_ff <= RSP_CNT_W'(RSP_DEPTH - 2), "results pushed into a full queue")
   `NVRC_ASSERT_IMPLY(a_pair_last_on_second, push.count == 2'd2, push.second.last && !push.first.last, "last flag misplaced on a result pair")

endmodule
